// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/tsd_pkg.sv
// Types and constants of the touch swipe direction unit.
`default_nettype none
package tsd_pkg;

    localparam int unsigned LIMIT_W   = 13;
    localparam int unsigned COORD_W   = 12;
    localparam int unsigned TYPE_W    = 5;
    localparam int unsigned CODE_W    = 10;
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned CFG_IDX_W = 4;

    localparam logic [LIMIT_W-1:0] X_LIMIT_RST = 13'd1024;
    localparam logic [LIMIT_W-1:0] Y_LIMIT_RST = 13'd600;

    localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT = 4'd1;

    localparam logic [TYPE_W-1:0] EVT_KEY = 5'd1;
    localparam logic [TYPE_W-1:0] EVT_ABS = 5'd3;

    localparam logic [CODE_W-1:0] CODE_X     = 10'd0;
    localparam logic [CODE_W-1:0] CODE_Y     = 10'd1;
    localparam logic [CODE_W-1:0] CODE_TOUCH = 10'd330;

    localparam logic [COORD_W-1:0] COORD_MAX = 12'd4095;

    // floor(n/5) == (n * 26215) >> 17 for every n below 2^15
    localparam logic [14:0] DIV5_MUL   = 15'd26215;
    localparam int unsigned DIV5_SHIFT = 17;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

endpackage
`default_nettype wire

// File: rtl/touch_swipe_direction_unit.sv
// Swipe direction detector: turns touch events into one end point and direction per gesture.
`default_nettype none
`include "assert_macros.svh"

// Touch swipe direction unit. Each input item is one touch event (type, code, value).
// Absolute X events with 0 < value < x_limit are scaled by 25/32, absolute Y events
// with 0 < value < y_limit by 4/5, truncating and saturating at 4095. The first
// accepted X and Y of a gesture form the start point; each accepted one moves the end
// point. A touch-release key event (key 330, value 0) gives one result item: the end
// point and the direction (up, down, left, right) found by comparing |dx| with |dy|,
// then the gesture state is cleared. Every other event gives no result. Rate: one item
// per clock while no release item is stalled; an item is registered on acceptance in
// the input register and handled from there, and its result is registered in the
// result register. The only stall comes from the result register: a release item waits
// while an earlier result is untaken.
// Limits are written through cfg_wr_en/cfg_index/cfg_wdata; the user must write them
// only while the unit is idle (not enforced); writes to other indexes are ignored.
module touch_swipe_direction_unit (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // configuration
    input  wire                                   cfg_wr_en,
    input  wire  [tsd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire  [tsd_pkg::LIMIT_W-1:0]           cfg_wdata,
    // event items in
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire  [tsd_pkg::TYPE_W-1:0]            s_event_type,
    input  wire  [tsd_pkg::CODE_W-1:0]            s_event_code,
    input  wire  signed [tsd_pkg::VALUE_W-1:0]    s_event_value,
    // result items out
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic [tsd_pkg::COORD_W-1:0]           m_end_x,
    output logic [tsd_pkg::COORD_W-1:0]           m_end_y,
    output logic [1:0]                            m_direction
);
    import tsd_pkg::*;

    // configuration registers
    logic [LIMIT_W-1:0] x_limit_reg;
    logic [LIMIT_W-1:0] y_limit_reg;

    // input register
    logic                             in_valid_reg;
    logic [TYPE_W-1:0]                in_type_reg;
    logic [CODE_W-1:0]                in_code_reg;
    logic signed [VALUE_W-1:0]        in_value_reg;

    // gesture state; an unseen start reads as -1
    logic                x_seen_reg, x_seen_next;
    logic                y_seen_reg, y_seen_next;
    logic [COORD_W-1:0]  start_x_reg, start_x_next;
    logic [COORD_W-1:0]  start_y_reg, start_y_next;
    logic [COORD_W-1:0]  last_x_reg, last_x_next;
    logic [COORD_W-1:0]  last_y_reg, last_y_next;

    // result register
    logic                m_valid_reg;
    logic [COORD_W-1:0]  end_x_reg;
    logic [COORD_W-1:0]  end_y_reg;
    dir_t                dir_reg;

    // decode
    logic                val_pos;
    logic                is_x, is_y, is_release;
    logic [LIMIT_W-1:0]  raw13;
    logic [17:0]         x_prod;
    logic [LIMIT_W-1:0]  x_scaled_w;
    logic [COORD_W-1:0]  x_scaled;
    logic [14:0]         y_times4;
    logic [29:0]         y_prod;
    logic [LIMIT_W-1:0]  y_scaled_w;
    logic [COORD_W-1:0]  y_scaled;

    // direction
    logic signed [LIMIT_W-1:0] sx, sy, lx, ly, dx, dy;
    logic [LIMIT_W-1:0]        adx, ady;
    dir_t                      dir_w;

    // handshake
    logic out_free, advance, rel_fire;

    // ---------------------------------------------------------------
    // Event decode and scaling
    // ---------------------------------------------------------------
    assign val_pos = !in_value_reg[VALUE_W-1] && (in_value_reg != '0);
    assign raw13   = in_value_reg[LIMIT_W-1:0];

    assign is_x = (in_type_reg == EVT_ABS) && (in_code_reg == CODE_X) && val_pos &&
                  (in_value_reg < $signed({{(VALUE_W-LIMIT_W){1'b0}}, x_limit_reg}));
    assign is_y = (in_type_reg == EVT_ABS) && (in_code_reg == CODE_Y) && val_pos &&
                  (in_value_reg < $signed({{(VALUE_W-LIMIT_W){1'b0}}, y_limit_reg}));
    assign is_release = (in_type_reg == EVT_KEY) && (in_code_reg == CODE_TOUCH) &&
                        (in_value_reg == '0);

    // x * 25 / 32: raw is below 8192, so the product fits 18 bits
    assign x_prod     = 18'({5'd0, raw13} * 18'd25);
    assign x_scaled_w = x_prod[17:5];
    assign x_scaled   = (x_scaled_w > {1'b0, COORD_MAX}) ? COORD_MAX
                                                         : x_scaled_w[COORD_W-1:0];

    // y * 4 / 5 via reciprocal multiply
    assign y_times4   = {raw13, 2'b00};
    assign y_prod     = 30'({15'd0, y_times4} * {15'd0, DIV5_MUL});
    assign y_scaled_w = y_prod[DIV5_SHIFT +: LIMIT_W];
    assign y_scaled   = (y_scaled_w > {1'b0, COORD_MAX}) ? COORD_MAX
                                                         : y_scaled_w[COORD_W-1:0];

    // ---------------------------------------------------------------
    // Direction: comparing |dx| and |dy| equals comparing the squares
    // ---------------------------------------------------------------
    assign sx = x_seen_reg ? $signed({1'b0, start_x_reg}) : '1;
    assign sy = y_seen_reg ? $signed({1'b0, start_y_reg}) : '1;
    assign lx = $signed({1'b0, last_x_reg});
    assign ly = $signed({1'b0, last_y_reg});
    assign dx = sx - lx;
    assign dy = sy - ly;
    // -4096 negates to 4096, still right as unsigned 13 bits
    assign adx = dx[LIMIT_W-1] ? LIMIT_W'(-dx) : LIMIT_W'(dx);
    assign ady = dy[LIMIT_W-1] ? LIMIT_W'(-dy) : LIMIT_W'(dy);

    always_comb begin
        priority if (sy > ly && ady > adx) begin
            dir_w = DIR_UP;
        end else if (sy < ly && ady > adx) begin
            dir_w = DIR_DOWN;
        end else if (sx > lx && adx > ady) begin
            dir_w = DIR_LEFT;
        end else begin
            dir_w = DIR_RIGHT;
        end
    end

    // ---------------------------------------------------------------
    // Flow control: only a release item needs the result register
    // ---------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!is_release || out_free);
    assign rel_fire = in_valid_reg && is_release && out_free;
    assign s_ready  = !in_valid_reg || advance;

    // ---------------------------------------------------------------
    // Gesture state next values
    // ---------------------------------------------------------------
    always_comb begin
        x_seen_next  = x_seen_reg;
        y_seen_next  = y_seen_reg;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        if (advance) begin
            if (rel_fire) begin
                x_seen_next = 1'b0;
                y_seen_next = 1'b0;
                last_x_next = '0;
                last_y_next = '0;
            end
            if (is_x) begin
                if (!x_seen_reg) begin
                    start_x_next = x_scaled;
                end
                x_seen_next = 1'b1;
                last_x_next = x_scaled;
            end
            if (is_y) begin
                if (!y_seen_reg) begin
                    start_y_next = y_scaled;
                end
                y_seen_next = 1'b1;
                last_y_next = y_scaled;
            end
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_limit_reg  <= X_LIMIT_RST;
            y_limit_reg  <= Y_LIMIT_RST;
            in_valid_reg <= 1'b0;
            x_seen_reg   <= 1'b0;
            y_seen_reg   <= 1'b0;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_X_LIMIT: x_limit_reg <= cfg_wdata;
                    CFG_Y_LIMIT: y_limit_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            x_seen_reg <= x_seen_next;
            y_seen_reg <= y_seen_next;
            last_x_reg <= last_x_next;
            last_y_reg <= last_y_next;
            if (out_free) begin
                m_valid_reg <= rel_fire;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_type_reg  <= s_event_type;
            in_code_reg  <= s_event_code;
            in_value_reg <= s_event_value;
        end
        start_x_reg <= start_x_next;
        start_y_reg <= start_y_next;
        if (rel_fire) begin
            end_x_reg <= last_x_reg;
            end_y_reg <= last_y_reg;
            dir_reg   <= dir_w;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_end_x     = end_x_reg;
    assign m_end_y     = end_y_reg;
    assign m_direction = dir_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ASSERT_NEXT(a_release_gives_result, aclk, aresetn, rel_fire, m_valid_reg,
                 "release item lost")
    `ASSERT_NEXT(a_release_clears, aclk, aresetn, rel_fire,
                 !x_seen_reg && !y_seen_reg && last_x_reg == '0 && last_y_reg == '0,
                 "gesture not cleared")
    `ASSERT_ALWAYS(a_stall_only_on_output, aclk, aresetn,
                   !(in_valid_reg && !advance) || (m_valid_reg && !m_ready),
                   "input stage stalled without cause")
    `ASSERT_ALWAYS(a_result_from_release, aclk, aresetn,
                   !$rose(m_valid_reg) || $past(rel_fire), "result without release")

endmodule
`default_nettype wire
